// ----- rtl/smt_pkg.sv -----
// Package for the sorted multimap table: request and status codes,
// controller/datapath command and status structs. No dependencies.
package smt_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    rd_cur;
    logic    walk_step;
    logic    match_step;
    logic    emit_pend;
    logic    emit_final;
    logic    ins_write;
    logic    ins_link;
    logic    del_commit;
    logic    scan_step;
    logic    set_res;
    status_t res_code;
  } smt_cmd_t;

  typedef struct packed {
    req_type_t req;
    logic      full;
    logic      cur_null;
    logic      pred_null;
    logic      walk_cont;
    logic      link_null;
    logic      is_match;
    logic      pend_valid;
    logic      del_found;
    logic      scan_done;
    logic      out_free;
  } smt_stat_t;

endpackage

// ----- rtl/smt_req_if.sv -----
// Request channel: valid/ready handshake with request type, key and value.
// Depends on smt_pkg for field widths.
interface smt_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [smt_pkg::REQ_W-1:0]    req_type;
  logic signed [KEY_BITS-1:0]   key;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

// ----- rtl/smt_rsp_if.sv -----
// Response channel: valid/ready handshake with status, value, last and count.
// Depends on smt_pkg for field widths.
interface smt_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [smt_pkg::STATUS_W-1:0] status;
  logic signed [VALUE_BITS-1:0] found_value;
  logic                         last;
  logic [smt_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_value, output last,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_value, input last,
                  input entry_count, output ready);
endinterface

// ----- rtl/sorted_multimap_table.sv -----
// Sorted key/value multimap, one request at a time. After the accept edge: a dispatch step,
// then a walk step per slot walked (at most CAPACITY). Insert adds a write step, a link step
// unless the pair becomes the head, and a free-slot scan. Search emits a beat per match
// (or one not-found beat); every other request loads its one beat through the finish flag
// once the output is free. Output stalls hold the sequence; the next request is taken after the last beat.
// Synchronous reset empties the table and its pointers and selects ascending order.
module sorted_multimap_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  smt_req_if.sink   req,
  smt_rsp_if.source rsp,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  smt_pkg::smt_cmd_t  cmd;
  smt_pkg::smt_stat_t stat;

  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req_type     (req.req_type),
    .in_key          (req.key),
    .in_value        (req.value),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_found_value (rsp.found_value),
    .out_last        (rsp.last),
    .out_entry_count (rsp.entry_count)
  );

endmodule

// ----- rtl/smt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/smt_ctrl.sv -----
// Request sequencer: dispatch, list walk, match emit, insert/delete update,
// free-slot scan. Depends on smt_pkg command and status structs.
module smt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smt_pkg::smt_stat_t stat,
  output smt_pkg::smt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_MATCH,
    S_DEL,
    S_INS_WRITE,
    S_INS_LINK,
    S_SCAN
  } state_t;

  state_t state, state_next;
  logic   finish, finish_next;
  state_t walk_exit;

  always_comb begin
    case (stat.req)
      smt_pkg::REQ_INSERT: walk_exit = S_INS_WRITE;
      smt_pkg::REQ_SEARCH: walk_exit = S_MATCH;
      smt_pkg::REQ_DELETE: walk_exit = S_DEL;
      default:             walk_exit = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !finish;

  always_comb begin
    cmd         = '0;
    cmd.res_code = smt_pkg::ST_OK;
    state_next  = state;
    finish_next = finish;
    if (finish) begin
      if (stat.out_free) begin
        cmd.emit_final = 1'b1;
        finish_next    = 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (stat.req == smt_pkg::REQ_CLEAR) begin
            cmd.clear   = 1'b1;
            cmd.set_res = 1'b1;
            finish_next = 1'b1;
            state_next  = S_IDLE;
          end else if (stat.req == smt_pkg::REQ_INSERT && stat.full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = smt_pkg::ST_FULL;
            finish_next  = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.cur_null) begin
            state_next = walk_exit;
          end else begin
            cmd.rd_cur = 1'b1;
            state_next = S_WALK;
          end
        end
        S_WALK: begin
          if (stat.walk_cont) begin
            cmd.walk_step = 1'b1;
            if (stat.link_null) begin
              state_next = walk_exit;
            end
          end else begin
            state_next = walk_exit;
          end
        end
        S_MATCH: begin
          if (stat.pend_valid && !stat.out_free) begin
            state_next = S_MATCH;
          end else if (stat.is_match) begin
            cmd.emit_pend  = stat.pend_valid;
            cmd.match_step = 1'b1;
          end else if (stat.pend_valid) begin
            cmd.emit_pend = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = smt_pkg::ST_NOT_FOUND;
            finish_next  = 1'b1;
            state_next   = S_IDLE;
          end
        end
        S_DEL: begin
          cmd.set_res = 1'b1;
          if (stat.del_found) begin
            cmd.del_commit = 1'b1;
          end else begin
            cmd.res_code = smt_pkg::ST_NOT_FOUND;
          end
          finish_next = 1'b1;
          state_next  = S_IDLE;
        end
        S_INS_WRITE: begin
          cmd.ins_write = 1'b1;
          state_next    = stat.pred_null ? S_SCAN : S_INS_LINK;
        end
        S_INS_LINK: begin
          cmd.ins_link = 1'b1;
          state_next   = S_SCAN;
        end
        S_SCAN: begin
          cmd.scan_step = 1'b1;
          if (stat.scan_done) begin
            cmd.set_res = 1'b1;
            finish_next = 1'b1;
            state_next  = S_IDLE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      finish <= 1'b0;
    end else begin
      state  <= state_next;
      finish <= finish_next;
    end
  end

endmodule

// ----- rtl/smt_datapath.sv -----
// Slot tables, list pointers, counters and result register of the multimap.
// Depends on smt_pkg and smt_ram.
module smt_datapath #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smt_pkg::smt_cmd_t             cmd,
  output smt_pkg::smt_stat_t            stat,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic [smt_pkg::REQ_W-1:0]     in_req_type,
  input  logic signed [KEY_BITS-1:0]    in_key,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [smt_pkg::STATUS_W-1:0]  out_status,
  output logic signed [VALUE_BITS-1:0]  out_found_value,
  output logic                          out_last,
  output logic [smt_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int KV_W   = KEY_BITS + VALUE_BITS;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  smt_pkg::req_type_t          req;
  smt_pkg::status_t            res;
  logic signed [KEY_BITS-1:0]   key_r;
  logic signed [VALUE_BITS-1:0] val_r;
  logic [LINK_W-1:0]            cur, pred, head, lowest, scan;
  logic [LINK_W-1:0]            steps, nres, count;
  logic [IDX_W-1:0]             slot_new;
  logic [CAPACITY-1:0]          used;
  logic signed [VALUE_BITS-1:0] pend_val;
  logic                         pend_valid;
  logic                         order_mode;

  logic                         kv_wr_en, kv_rd_en;
  logic [KV_W-1:0]              kv_rd_data;
  logic                         ln_wr_en;
  logic [IDX_W-1:0]             ln_wr_addr, rd_addr;
  logic [LINK_W-1:0]            ln_wr_data, rd_link;

  logic signed [KEY_BITS-1:0]   k_cur;
  logic signed [VALUE_BITS-1:0] v_cur;
  logic                         keq, veq, rel, out_free, step_rd;

  assign k_cur = kv_rd_data[KV_W-1 -: KEY_BITS];
  assign v_cur = kv_rd_data[VALUE_BITS-1:0];
  assign keq   = (k_cur == key_r);
  assign veq   = (v_cur == val_r);
  assign rel   = order_mode ? (k_cur >= key_r) : (k_cur <= key_r);

  assign out_free = !out_valid || out_ready;
  assign step_rd  = (cmd.walk_step || cmd.match_step) && (rd_link < NULL_LINK);

  always_comb begin
    stat            = '0;
    stat.req        = req;
    stat.full       = (count >= NULL_LINK) || (lowest >= NULL_LINK);
    stat.cur_null   = (cur >= NULL_LINK);
    stat.pred_null  = (pred >= NULL_LINK);
    stat.link_null  = (rd_link >= NULL_LINK);
    stat.walk_cont  = (steps < NULL_LINK) && rel &&
                      ((req == smt_pkg::REQ_DELETE) ? !(keq && veq) : !keq);
    stat.is_match   = (cur < NULL_LINK) && keq && (nres < NULL_LINK);
    stat.pend_valid = pend_valid;
    stat.del_found  = (cur < NULL_LINK) && keq && veq;
    stat.scan_done  = (scan >= NULL_LINK) || !used[scan[IDX_W-1:0]];
    stat.out_free   = out_free;
  end

  assign rd_addr  = cmd.rd_cur ? cur[IDX_W-1:0] : rd_link[IDX_W-1:0];
  assign kv_rd_en = cmd.rd_cur || step_rd;
  assign kv_wr_en = cmd.ins_write;

  always_comb begin
    ln_wr_en   = 1'b0;
    ln_wr_addr = pred[IDX_W-1:0];
    ln_wr_data = rd_link;
    if (cmd.ins_write) begin
      ln_wr_en   = 1'b1;
      ln_wr_addr = lowest[IDX_W-1:0];
      ln_wr_data = cur;
    end else if (cmd.ins_link) begin
      ln_wr_en   = 1'b1;
      ln_wr_data = LINK_W'(slot_new);
    end else if (cmd.del_commit && pred < NULL_LINK) begin
      ln_wr_en = 1'b1;
    end
  end

  smt_ram #(.WIDTH(KV_W), .DEPTH(CAPACITY)) u_kv_ram (
    .clk     (clk),
    .wr_en   (kv_wr_en),
    .wr_addr (lowest[IDX_W-1:0]),
    .wr_data ({key_r, val_r}),
    .rd_en   (kv_rd_en),
    .rd_addr (rd_addr),
    .rd_data (kv_rd_data)
  );

  smt_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk     (clk),
    .wr_en   (ln_wr_en),
    .wr_addr (ln_wr_addr),
    .wr_data (ln_wr_data),
    .rd_en   (kv_rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_link)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= smt_pkg::req_type_t'(in_req_type);
      key_r <= in_key;
      val_r <= in_value;
      pred  <= NULL_LINK;
      steps <= '0;
      nres  <= '0;
    end
    if (cmd.set_res) begin
      res <= cmd.res_code;
    end
    if (cmd.walk_step) begin
      pred  <= cur;
      steps <= steps + 1'b1;
    end
    if (cmd.match_step) begin
      pend_val <= v_cur;
      nres     <= nres + 1'b1;
    end
    if (cmd.ins_write) begin
      slot_new <= lowest[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      head       <= NULL_LINK;
      lowest     <= '0;
      count      <= '0;
      cur        <= NULL_LINK;
      scan       <= '0;
      pend_valid <= 1'b0;
      order_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_mode <= cfg_wr_data;
      end
      if (cmd.load) begin
        cur        <= head;
        pend_valid <= 1'b0;
      end
      if (cmd.walk_step || cmd.match_step) begin
        cur <= rd_link;
      end
      if (cmd.match_step) begin
        pend_valid <= 1'b1;
      end
      if (cmd.clear) begin
        used   <= '0;
        head   <= NULL_LINK;
        lowest <= '0;
        count  <= '0;
      end
      if (cmd.ins_write) begin
        used[lowest[IDX_W-1:0]] <= 1'b1;
        count <= count + 1'b1;
        scan  <= lowest + 1'b1;
        if (pred >= NULL_LINK) begin
          head <= lowest;
        end
      end
      if (cmd.scan_step) begin
        if (scan >= NULL_LINK) begin
          lowest <= NULL_LINK;
        end else if (!used[scan[IDX_W-1:0]]) begin
          lowest <= scan;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      if (cmd.del_commit) begin
        used[cur[IDX_W-1:0]] <= 1'b0;
        if (cur < lowest) begin
          lowest <= cur;
        end
        if (count != '0) begin
          count <= count - 1'b1;
        end
        if (pred >= NULL_LINK) begin
          head <= rd_link;
        end
      end
      if (cmd.emit_pend || cmd.emit_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pend) begin
      out_status      <= smt_pkg::ST_OK;
      out_found_value <= pend_val;
      out_last        <= !stat.is_match;
      out_entry_count <= smt_pkg::COUNT_W'(count);
    end else if (cmd.emit_final) begin
      out_status      <= res;
      out_found_value <= '0;
      out_last        <= 1'b1;
      out_entry_count <= smt_pkg::COUNT_W'(count);
    end
  end

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("stored count disagrees with occupied slots");

  a_head_null_iff_empty: assert property (@(posedge clk) disable iff (rst)
    (head >= NULL_LINK) == (count == '0))
    else $error("list head inconsistent with stored count");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != smt_pkg::ST_OK) |-> out_last)
    else $error("error beat without last mark");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= NULL_LINK)
    else $error("stored count above capacity");

endmodule
